// ----- hw/rtl/lacq_pkg.sv -----
// Shared constants and codes for the serial line assembler with command queue.
package lacq_pkg;

  localparam int LINE_MAX_DEF    = 64;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_SOURCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'd1;

  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd150;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;

  localparam logic [2:0] EV_NOTHING      = 3'd0;
  localparam logic [2:0] EV_COMMIT       = 3'd1;
  localparam logic [2:0] EV_DROPPED      = 3'd2;
  localparam logic [2:0] EV_OVERLONG     = 3'd3;
  localparam logic [2:0] EV_CHAR         = 3'd4;
  localparam logic [2:0] EV_EMPTY        = 3'd5;
  localparam logic [2:0] EV_POPPED_EMPTY = 3'd6;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_POP  = 1'b1;

endpackage

// ----- hw/rtl/lacq_text_ram.sv -----
// Simple dual-port text memory: one write port, one registered read port.
module lacq_text_ram #(
  parameter int ADDR_W = 9,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/line_assembler_command_queue.sv -----
// Serial line assembler with idle timeout and a ring of stored lines.
//
// Input channel in_*: in_tuser carries the opcode (byte, tick, pop), in_tdata the
// received byte, the millisecond time and the reader buffer size. Output channel
// out_*: out_tuser the event code, out_tdata the popped character, the line source
// and the count of queued lines; out_tlast marks the final result of an item.
// The cfg_* port writes the reply source tag and the idle timeout.
// Lines are assembled in place in the free head slot of the text memory, so a
// commit only writes the terminating zero and the source tag and advances the head.
// Byte and tick items, and a pop of an empty ring or with a buffer size of 0 or 1,
// present their result in the cycle after the input transfer. A pop of a line
// first fetches the first character from the text memory and then returns one
// character per cycle while the receiver accepts, set by the single read port of
// the text memory (registered read, one character ahead).
// A registered output stage holds each result; while the receiver stalls the
// result holds and no further item or character advances.
// Reset clears the ring pointers, the line length, the byte time, the output
// stage and the registers (timeout 150 ms); no clearing pass is needed.
module line_assembler_command_queue #(
  parameter int LINE_MAX    = lacq_pkg::LINE_MAX_DEF,
  parameter int QUEUE_DEPTH = lacq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [47:0]                       in_tdata,  // rx_byte, now_ms, max_len
  input  logic [1:0]                        in_tuser,  // opcode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata, // char_out, line_source, queued_lines
  output logic [2:0]                        out_tuser, // event_res
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [lacq_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [lacq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import lacq_pkg::*;

  localparam int LEN_W  = $clog2(LINE_MAX);
  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W = SLOT_W + LEN_W;

  localparam logic [LEN_W-1:0]  LEN_LAST  = LEN_W'(LINE_MAX - 1);
  localparam logic [8:0]        CAP_MAX   = 9'(LINE_MAX - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_DEPTH - 1);
  localparam logic [SLOT_W:0]   DEPTH_EXT = (SLOT_W + 1)'(QUEUE_DEPTH);

  logic [7:0]  in_byte;
  logic [31:0] in_now;
  logic [7:0]  in_max_len;
  logic [1:0]  in_opcode;

  assign in_byte    = in_tdata[7:0];
  assign in_now     = in_tdata[39:8];
  assign in_max_len = in_tdata[47:40];
  assign in_opcode  = in_tuser;

  logic [1:0]  reply_source_r;
  logic [15:0] idle_timeout_r;

  logic [0:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [31:0]       last_time_r, last_time_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [LEN_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [LEN_W-1:0]  cap_r, cap_nxt;
  logic [1:0]        src_r, src_nxt;
  logic              have_cur_r, have_cur_nxt;
  logic [7:0]        cur_r, cur_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_event_r;
  logic [7:0] out_char_r;
  logic [1:0] out_src_r;
  logic       out_last_r;
  logic [2:0] out_queued_r;

  logic [1:0] qsrc [QUEUE_DEPTH];
  logic       qsrc_we;

  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;

  logic              out_free;
  logic              in_accept;
  logic              commit_req;
  logic [SLOT_W-1:0] head_inc;
  logic [SLOT_W-1:0] tail_inc;
  logic [31:0]       elapsed;
  logic              expired;
  logic [8:0]        lim;
  logic [8:0]        cap9;
  logic [SLOT_W:0]   diff;
  logic [SLOT_W+2:0] cnt_ext;

  logic       load;
  logic [2:0] ld_event;
  logic [7:0] ld_char;
  logic [1:0] ld_src;
  logic       ld_last;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_accept = in_tvalid && in_tready;

  assign head_inc = (head_r == SLOT_LAST) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == SLOT_LAST) ? '0 : tail_r + 1'b1;

  assign elapsed = in_now - last_time_r;
  assign expired = elapsed > {16'd0, idle_timeout_r};

  assign lim  = (in_max_len == 8'd0) ? 9'd0 : {1'b0, in_max_len} - 9'd1;
  assign cap9 = (lim > CAP_MAX) ? CAP_MAX : lim;

  assign mem_waddr = {head_r, len_r};
  assign mem_raddr = {slot_nxt, rd_idx_nxt};

  lacq_text_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (8)
  ) u_text_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    len_nxt       = len_r;
    last_time_nxt = last_time_r;
    slot_nxt      = slot_r;
    rd_idx_nxt    = rd_idx_r;
    cap_nxt       = cap_r;
    src_nxt       = src_r;
    have_cur_nxt  = have_cur_r;
    cur_nxt       = cur_r;
    commit_req    = 1'b0;
    qsrc_we       = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = in_byte;
    load          = 1'b0;
    ld_event      = EV_NOTHING;
    ld_char       = 8'd0;
    ld_src        = 2'd0;
    ld_last       = 1'b1;

    if (in_accept) begin
      load = 1'b1;
      unique case (in_opcode)
        OP_BYTE: begin
          last_time_nxt = in_now;
          if (in_byte == CHAR_CR || in_byte == CHAR_LF) begin
            commit_req = (len_r != '0);
          end else if (len_r < LEN_LAST) begin
            mem_we  = 1'b1;
            len_nxt = len_r + 1'b1;
          end else begin
            len_nxt  = '0;
            ld_event = EV_OVERLONG;
          end
        end
        OP_TICK: begin
          commit_req = (len_r != '0) && expired;
        end
        OP_POP: begin
          if (head_r == tail_r) begin
            ld_event = EV_EMPTY;
          end else begin
            src_nxt      = qsrc[tail_r];
            tail_nxt     = tail_inc;
            slot_nxt     = tail_r;
            rd_idx_nxt   = '0;
            cap_nxt      = cap9[LEN_W-1:0];
            have_cur_nxt = 1'b0;
            if (cap9 == 9'd0) begin
              ld_event = EV_POPPED_EMPTY;
              ld_src   = qsrc[tail_r];
            end else begin
              load      = 1'b0;
              state_nxt = ST_POP;
            end
          end
        end
        default: begin
          ld_event = EV_NOTHING;
        end
      endcase

      if (commit_req) begin
        len_nxt = '0;
        if (head_inc != tail_r) begin
          mem_we    = 1'b1;
          mem_wdata = CHAR_NUL;
          qsrc_we   = 1'b1;
          head_nxt  = head_inc;
          ld_event  = EV_COMMIT;
        end else begin
          ld_event = EV_DROPPED;
        end
      end
    end else if (state_r == ST_POP) begin
      if (!have_cur_r) begin
        if (mem_rdata == CHAR_NUL) begin
          if (out_free) begin
            load      = 1'b1;
            ld_event  = EV_POPPED_EMPTY;
            ld_src    = src_r;
            state_nxt = ST_IDLE;
          end
        end else begin
          cur_nxt      = mem_rdata;
          have_cur_nxt = 1'b1;
          rd_idx_nxt   = rd_idx_r + 1'b1;
        end
      end else if (out_free) begin
        load     = 1'b1;
        ld_event = EV_CHAR;
        ld_char  = cur_r;
        ld_src   = src_r;
        ld_last  = (rd_idx_r == cap_r) || (mem_rdata == CHAR_NUL);
        if (ld_last) begin
          state_nxt    = ST_IDLE;
          have_cur_nxt = 1'b0;
        end else begin
          cur_nxt    = mem_rdata;
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (head_nxt >= tail_nxt) begin
      diff = {1'b0, head_nxt} - {1'b0, tail_nxt};
    end else begin
      diff = {1'b0, head_nxt} + DEPTH_EXT - {1'b0, tail_nxt};
    end
    cnt_ext = {3'd0, diff[SLOT_W-1:0]};
  end

  assign out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_source_r <= 2'd0;
      idle_timeout_r <= IDLE_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_REPLY_SOURCE: reply_source_r <= cfg_wdata[1:0];
        CFG_IDLE_TIMEOUT: idle_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      len_r       <= '0;
      last_time_r <= 32'd0;
      have_cur_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      len_r       <= len_nxt;
      last_time_r <= last_time_nxt;
      have_cur_r  <= have_cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    rd_idx_r <= rd_idx_nxt;
    cap_r    <= cap_nxt;
    src_r    <= src_nxt;
    cur_r    <= cur_nxt;
    if (load) begin
      out_event_r  <= ld_event;
      out_char_r   <= ld_char;
      out_src_r    <= ld_src;
      out_last_r   <= ld_last;
      out_queued_r <= cnt_ext[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (qsrc_we) begin
      qsrc[head_r] <= reply_source_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_event_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'd0, out_queued_r, out_src_r, out_char_r};

endmodule

// ----- tb/line_assembler_command_queue_test.sv -----
// Testbench for the line assembler: byte, tick and pop transfers checked by a predictor.
`timescale 1ns / 1ps

module line_assembler_command_queue_test;
  import lacq_pkg::*;

  localparam int          LINE_MAX    = LINE_MAX_DEF;
  localparam int          QUEUE_DEPTH = QUEUE_DEPTH_DEF;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          ITEM_TARGET = 320;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [7:0]  MAX_LEN_ALL = 8'd255;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] char_out;
    logic [1:0] line_source;
    logic       last;
    logic [2:0] queued_lines;
  } line_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor state
  logic [1:0]  m_src_tag;
  logic [15:0] m_timeout;
  logic [7:0]  m_line [LINE_MAX];
  int          m_len;
  logic [31:0] m_last_time;
  logic [7:0]  m_text [QUEUE_DEPTH][LINE_MAX];
  logic [1:0]  m_src [QUEUE_DEPTH];
  int          m_head;
  int          m_tail;

  line_result_t pending_results[$];
  int           err_count = 0;
  int           cycles = 0;
  int           items_sent;
  int           stall_left = 0;
  bit           idle_en;
  logic [31:0]  cur_time;

  line_assembler_command_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : check_results
    line_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, event", int'(out_tuser), -1);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser != want.event_res)
          report_mismatch("event_res", int'(out_tuser), int'(want.event_res));
        if (out_tdata[7:0] != want.char_out)
          report_mismatch("char_out", int'(out_tdata[7:0]), int'(want.char_out));
        if (out_tdata[9:8] != want.line_source)
          report_mismatch("line_source", int'(out_tdata[9:8]), int'(want.line_source));
        if (out_tdata[12:10] != want.queued_lines)
          report_mismatch("queued_lines", int'(out_tdata[12:10]), int'(want.queued_lines));
        if (out_tlast != want.last)
          report_mismatch("last", int'(out_tlast), int'(want.last));
      end
    end
  end

  task automatic clear_line_model();
    m_src_tag   = 2'd0;
    m_timeout   = IDLE_TIMEOUT_RST;
    m_len       = 0;
    m_last_time = 32'd0;
    m_head      = 0;
    m_tail      = 0;
    for (int i = 0; i < LINE_MAX; i++) m_line[i] = 8'd0;
    for (int q = 0; q < QUEUE_DEPTH; q++) begin
      m_src[q] = 2'd0;
      for (int i = 0; i < LINE_MAX; i++) m_text[q][i] = 8'd0;
    end
  endtask

  function automatic logic [2:0] lines_waiting();
    return 3'((m_head + QUEUE_DEPTH - m_tail) % QUEUE_DEPTH);
  endfunction

  function automatic logic [2:0] commit_held_line();
    int nxt;
    int i;
    nxt = (m_head + 1) % QUEUE_DEPTH;
    if (nxt == m_tail) begin
      m_len = 0;
      return EV_DROPPED;
    end
    for (i = 0; i < m_len && i < LINE_MAX - 1; i++) m_text[m_head][i] = m_line[i];
    m_text[m_head][i] = CHAR_NUL;
    m_src[m_head] = m_src_tag;
    m_head = nxt;
    m_len = 0;
    return EV_COMMIT;
  endfunction

  function automatic void expect_result(input logic [2:0] ev, input logic [7:0] ch,
                                        input logic [1:0] src, input logic last);
    line_result_t r;
    r.event_res    = ev;
    r.char_out     = ch;
    r.line_source  = src;
    r.last         = last;
    r.queued_lines = lines_waiting();
    pending_results.push_back(r);
  endfunction

  function automatic void predict_line_results(input logic [1:0] op, input logic [7:0] rx,
                                               input logic [31:0] now, input logic [7:0] mlen);
    logic [2:0] ev;
    logic [1:0] src;
    int         slot;
    int         n;
    int         lim;
    ev = EV_NOTHING;
    case (op)
      OP_BYTE: begin
        m_last_time = now;
        if (rx == CHAR_CR || rx == CHAR_LF) begin
          if (m_len > 0) ev = commit_held_line();
        end else if (m_len < LINE_MAX - 1) begin
          m_line[m_len] = rx;
          m_len++;
        end else begin
          m_len = 0;
          ev = EV_OVERLONG;
        end
        expect_result(ev, 8'd0, 2'd0, 1'b1);
      end
      OP_TICK: begin
        if (m_len > 0 && (now - m_last_time) > 32'(m_timeout)) ev = commit_held_line();
        expect_result(ev, 8'd0, 2'd0, 1'b1);
      end
      OP_POP: begin
        if (m_head == m_tail) begin
          expect_result(EV_EMPTY, 8'd0, 2'd0, 1'b1);
        end else begin
          slot = m_tail;
          src  = m_src[slot];
          n    = 0;
          while (n < LINE_MAX - 1 && m_text[slot][n] != CHAR_NUL) n++;
          lim = (mlen == 8'd0) ? 0 : int'(mlen) - 1;
          if (n > lim) n = lim;
          m_tail = (slot + 1) % QUEUE_DEPTH;
          if (n == 0) begin
            expect_result(EV_POPPED_EMPTY, 8'd0, src, 1'b1);
          end else begin
            for (int k = 0; k < n; k++)
              expect_result(EV_CHAR, m_text[slot][k], src, k == n - 1);
          end
        end
      end
      default: begin
        expect_result(EV_NOTHING, 8'd0, 2'd0, 1'b1);
      end
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] rx,
                           input logic [31:0] now, input logic [7:0] mlen);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (gap) @(negedge clk);
    in_tuser  = op;
    in_tdata  = {mlen, now, rx};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_line_results(op, rx, now, mlen);
    if (op != OP_UNUSED) items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_quiet();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_REPLY_SOURCE) m_src_tag = value[1:0];
    else m_timeout = value;
  endtask

  task automatic send_byte(input logic [7:0] rx, input logic [31:0] now);
    send_item(OP_BYTE, rx, now, 8'($urandom()));
  endtask

  task automatic send_pop(input logic [7:0] mlen);
    send_item(OP_POP, 8'($urandom()), $urandom(), mlen);
  endtask

  task automatic test_empty_cases();
    send_pop(MAX_LEN_ALL);
    send_item(OP_TICK, 8'h00, 32'd1000, 8'd1);
    send_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    send_byte(CHAR_LF, 32'hFFFF_FFFF);
  endtask

  task automatic test_line_commit();
    send_byte("A", 32'd10);
    send_byte(8'hFF, 32'd11);
    send_byte(CHAR_NUL, 32'd12);
    send_byte("B", 32'd13);
    send_byte(CHAR_CR, 32'd14);
    send_pop(MAX_LEN_ALL);
  endtask

  task automatic test_pop_limits();
    wait_quiet();
    write_reg(CFG_REPLY_SOURCE, 16'd3);
    send_byte("x", 32'd20);
    send_byte("y", 32'd21);
    send_byte(CHAR_LF, 32'd22);
    send_pop(8'd2);
    send_byte("q", 32'd23);
    send_byte(CHAR_CR, 32'd24);
    send_pop(8'd0);
    send_byte("a", 32'd25);
    send_byte(CHAR_CR, 32'd26);
    send_pop(8'd1);
  endtask

  task automatic test_idle_timeout();
    wait_quiet();
    write_reg(CFG_IDLE_TIMEOUT, 16'd0);
    send_byte("k", 32'hFFFF_FFFF);
    send_item(OP_TICK, 8'h00, 32'hFFFF_FFFF, 8'd0);
    send_item(OP_TICK, 8'h00, 32'h0000_0000, 8'd0);
    wait_quiet();
    write_reg(CFG_IDLE_TIMEOUT, 16'hFFFF);
    send_byte("m", 32'h8000_0000);
    send_item(OP_TICK, 8'h00, 32'h8000_FFFF, 8'd0);
    send_item(OP_TICK, 8'h00, 32'h8001_0000, 8'd0);
    send_pop(MAX_LEN_ALL);
    send_pop(MAX_LEN_ALL);
  endtask

  task automatic send_tick();
    logic [31:0] span;
    case ($urandom_range(0, 4))
      0:       span = 32'(m_timeout) - 32'd1;
      1:       span = 32'(m_timeout);
      2:       span = 32'(m_timeout) + 32'd1;
      3:       span = $urandom_range(0, 300);
      default: span = $urandom();
    endcase
    cur_time = m_last_time + span;
    send_item(OP_TICK, 8'($urandom()), cur_time, 8'($urandom()));
  endtask

  task automatic send_random_line();
    int          len;
    logic [7:0]  ch;
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(58, 66) : $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 24))
        0:       ch = CHAR_NUL;
        1, 2:    ch = 8'($urandom());
        default: ch = 8'($urandom_range(8'h20, 8'h7E));
      endcase
      if (ch == CHAR_CR || ch == CHAR_LF) ch = 8'h80 | ch;
      cur_time = cur_time + $urandom_range(0, 5);
      send_byte(ch, cur_time);
    end
    cur_time = cur_time + $urandom_range(0, 5);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_byte(CHAR_CR, cur_time);
      4, 5, 6:    send_byte(CHAR_LF, cur_time);
      default:    send_tick();
    endcase
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 3) == 0) cur_time = $urandom();
    if ($urandom_range(0, 3) == 0) cur_time = 32'hFFFF_FFF0 + $urandom_range(0, 15);
    send_item(2'($urandom_range(0, 3)), 8'($urandom()), cur_time, 8'($urandom()));
  endtask

  task automatic test_random_traffic();
    logic [1:0]  src_set [4];
    logic [15:0] timeout_set [4];
    int          phase_end;
    bit          paused;
    src_set     = '{2'd1, 2'd3, 2'd2, 2'd0};
    timeout_set = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 400)), IDLE_TIMEOUT_RST};
    cur_time = $urandom();
    for (int p = 0; p < 4; p++) begin
      wait_quiet();
      write_reg(CFG_REPLY_SOURCE, 16'(src_set[p]));
      write_reg(CFG_IDLE_TIMEOUT, timeout_set[p]);
      phase_end = items_sent + ITEM_TARGET / 4;
      paused = 1'b0;
      while (items_sent < phase_end) begin
        idle_en = (p < 3) && ($urandom_range(0, 5) != 0);
        if (!paused && items_sent > phase_end - ITEM_TARGET / 8) begin
          wait_quiet();
          paused = 1'b1;
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_random_line();
          6, 7:             send_pop(($urandom_range(0, 3) != 0) ? MAX_LEN_ALL
                                                                 : 8'($urandom_range(0, 255)));
          8:                send_tick();
          default:          send_noise();
        endcase
      end
    end
    idle_en = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_BYTE;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_REPLY_SOURCE;
    cfg_wdata  = '0;
    items_sent = 0;
    idle_en    = 1'b1;
    cur_time   = 32'd0;
    clear_line_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_cases();
    test_line_commit();
    test_pop_limits();
    test_idle_timeout();
    test_random_traffic();

    wait_quiet();
    repeat (10) @(negedge clk);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/lacq_pkg.sv
hw/rtl/lacq_text_ram.sv
hw/rtl/line_assembler_command_queue.sv
tb/line_assembler_command_queue_test.sv
